// File: rtl/core/rtcrf_pkg.sv
// ----------------------------------------------------------------------------
// rtcrf_pkg
// Shared types, register map, masks and helper functions of the RTC
// register file.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcrf_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_FINISH = 2'd2,
    OP_EVENT  = 2'd3
  } rtcrf_op_t;

  // Register map
  localparam logic [7:0] ADDR_CTRL1   = 8'h00;
  localparam logic [7:0] ADDR_CTRL2   = 8'h01;
  localparam logic [7:0] ADDR_SECONDS = 8'h02;
  localparam logic [7:0] ADDR_YEARS   = 8'h08;
  localparam logic [7:0] ADDR_ALARM0  = 8'h09;
  localparam logic [7:0] ADDR_ALARM3  = 8'h0C;
  localparam logic [7:0] ADDR_CLKOUT  = 8'h0D;
  localparam logic [7:0] ADDR_TMRCTL  = 8'h0E;
  localparam logic [7:0] ADDR_TMRCNT  = 8'h0F;

  // Write masks
  localparam logic [7:0] CTRL1_MASK  = 8'hA8;
  localparam logic [4:0] CTRL2_MASK  = 5'h1F;
  localparam logic [7:0] ALARM_MASK  = 8'hBF;
  localparam logic [7:0] WDAY_MASK   = 8'h87;
  localparam logic [7:0] CTL_MASK    = 8'h83;
  localparam logic [7:0] UNMAPPED    = 8'hFF;

  // Reset values
  localparam logic [7:0] CTRL1_RST   = 8'h08;
  localparam logic [7:0] ALARM_RST   = 8'h80;
  localparam logic [7:0] CTL_RST     = 8'h83;

  // control_two and timer control bit positions
  localparam int unsigned C2_TIE   = 0;
  localparam int unsigned C2_AIE   = 1;
  localparam int unsigned C2_TF    = 2;
  localparam int unsigned C2_AF    = 3;
  localparam int unsigned C2_TI_TP = 4;
  localparam int unsigned TC_TE    = 7;

  localparam int unsigned NUM_TIME  = 7;
  localparam int unsigned NUM_ALARM = 4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
    logic       irq_pulse;
  } rtcrf_result_t;

  // Field mask applied before BCD decode
  function automatic logic [7:0] time_mask(input logic [2:0] idx);
    logic [7:0] m;
    case (idx)
      3'd0, 3'd1: m = 8'h7F;
      3'd2, 3'd3: m = 8'h3F;
      3'd4:       m = 8'h07;
      3'd5:       m = 8'h1F;
      default:    m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] time_low(input logic [2:0] idx);
    return (idx == 3'd3 || idx == 3'd5) ? 7'd1 : 7'd0;
  endfunction

  function automatic logic [6:0] time_high(input logic [2:0] idx);
    logic [6:0] h;
    case (idx)
      3'd0, 3'd1: h = 7'd59;
      3'd2:       h = 7'd23;
      3'd3:       h = 7'd31;
      3'd4:       h = 7'd6;
      3'd5:       h = 7'd12;
      default:    h = 7'd99;
    endcase
    return h;
  endfunction

  // tens*10 + units, nibbles above nine included
  function automatic logic [7:0] bcd_decode(input logic [7:0] v);
    logic [7:0] tens;
    tens = {4'd0, v[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, v[3:0]};
  endfunction

  // Binary 0..99 to two BCD digits; tens by reciprocal multiply (205/2048)
  function automatic logic [7:0] bcd_encode(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {8'd0, v} * 15'd205;
    tens  = prod[14:11];
    units = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
    return {tens, units[3:0]};
  endfunction

  // Interrupt evaluation: returns {line, pulse}
  function automatic logic [1:0] irq_eval(input logic [4:0] c2);
    logic line;
    logic pulse;
    line  = 1'b0;
    pulse = 1'b0;
    if (c2[C2_TF] && c2[C2_TIE]) begin
      if (c2[C2_TI_TP]) pulse = 1'b1;
      else              line  = 1'b1;
    end
    if (c2[C2_AF] && c2[C2_AIE]) line = 1'b1;
    return {line, pulse};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rtcrf_chan_if.sv
// ----------------------------------------------------------------------------
// rtcrf channel interfaces
// Valid/ready request and result channels of the RTC register file.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtcrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [1:0] tick_source;
  logic       is_tick;

  modport source (output valid, opcode, data_byte, tick_source, is_tick, input ready);
  modport sink   (input valid, opcode, data_byte, tick_source, is_tick, output ready);
endinterface

interface rtcrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_level;
  logic       irq_pulse;

  modport source (output valid, read_data, irq_level, irq_pulse, input ready);
  modport sink   (input valid, read_data, irq_level, irq_pulse, output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2c_rtc_register_file.sv
// ----------------------------------------------------------------------------
// i2c_rtc_register_file
// Byte-level register file of an I2C real-time clock with countdown timer,
// alarm flag and interrupt generation.
// ----------------------------------------------------------------------------
// Each request (bus write byte, bus read byte, transfer finish or time event)
// yields exactly one result. A request is captured in an input register and
// processed from there into the result register; a stalled result keeps it
// in the input register. One request is accepted every cycle as long as
// results are taken; the input register and the result register together
// hold at most two requests, and the input is ready whenever the input
// register is empty or the result register can advance. There are no
// memories and no startup sweep: reset loads the control and architectural
// registers with their documented values; payload registers are not reset.
`default_nettype none

module i2c_rtc_register_file (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rtcrf_in_if.sink    in_ch,
  rtcrf_out_if.source out_ch
);
  import rtcrf_pkg::*;

  // Pipeline control
  logic          in_v_r;
  logic          out_v_r;
  logic          adv;

  // Captured request
  rtcrf_op_t     op_r;
  logic [7:0]    data_r;
  logic [1:0]    src_r;
  logic          tick_r;

  rtcrf_result_t res_r;
  rtcrf_result_t res_nxt;

  // Architectural state
  logic [7:0] ptr_r,    ptr_nxt;
  logic       expa_r,   expa_nxt;
  logic [7:0] ctrl1_r,  ctrl1_nxt;
  logic [4:0] ctrl2_r,  ctrl2_nxt;
  logic       vlow_r,   vlow_nxt;
  logic [6:0] time_r    [NUM_TIME];
  logic [6:0] time_nxt  [NUM_TIME];
  logic [7:0] alarm_r   [NUM_ALARM];
  logic [7:0] alarm_nxt [NUM_ALARM];
  logic [7:0] clkout_r, clkout_nxt;
  logic [7:0] tmrctl_r, tmrctl_nxt;
  logic [7:0] tmrcnt_r, tmrcnt_nxt;
  logic       run_r,    run_nxt;
  logic       irq_r,    irq_nxt;

  // Address decode helpers
  logic [2:0] tidx;
  logic [1:0] aidx;
  logic [7:0] tval;
  logic       t_ok;
  logic       is_time;
  logic       is_alarm;
  logic [7:0] alarm_mask;
  logic [1:0] ev;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || adv;

  assign out_ch.valid     = out_v_r;
  assign out_ch.read_data = res_r.read_data;
  assign out_ch.irq_level = res_r.irq_level;
  assign out_ch.irq_pulse = res_r.irq_pulse;

  // Decode the pointer into time and alarm slots
  assign tidx     = ptr_r[2:0] - 3'd2;
  assign aidx     = ptr_r[1:0] - 2'd1;
  assign is_time  = (ptr_r >= ADDR_SECONDS) && (ptr_r <= ADDR_YEARS);
  assign is_alarm = (ptr_r >= ADDR_ALARM0) && (ptr_r <= ADDR_ALARM3);
  assign tval     = bcd_decode(data_r & time_mask(tidx));
  assign t_ok     = (tval >= {1'b0, time_low(tidx)}) && (tval <= {1'b0, time_high(tidx)});
  assign alarm_mask = (aidx == 2'd0) ? UNMAPPED :
                      (aidx == 2'd3) ? WDAY_MASK : ALARM_MASK;

  // Next state and result for the captured request
  always_comb begin
    ptr_nxt    = ptr_r;
    expa_nxt   = expa_r;
    ctrl1_nxt  = ctrl1_r;
    ctrl2_nxt  = ctrl2_r;
    vlow_nxt   = vlow_r;
    time_nxt   = time_r;
    alarm_nxt  = alarm_r;
    clkout_nxt = clkout_r;
    tmrctl_nxt = tmrctl_r;
    tmrcnt_nxt = tmrcnt_r;
    run_nxt    = run_r;
    irq_nxt    = irq_r;
    ev         = 2'b00;
    res_nxt.read_data = UNMAPPED;
    res_nxt.irq_pulse = 1'b0;

    unique case (op_r)
      OP_WRITE: begin
        if (expa_r) begin
          ptr_nxt  = data_r;
          expa_nxt = 1'b0;
        end else begin
          ptr_nxt = ptr_r + 8'd1;
          if (ptr_r == ADDR_CTRL1) begin
            ctrl1_nxt = data_r & CTRL1_MASK;
          end else if (ptr_r == ADDR_CTRL2) begin
            ctrl2_nxt = data_r[4:0] & CTRL2_MASK;
          end else if (is_time) begin
            if (t_ok) time_nxt[tidx] = tval[6:0];
            if (ptr_r == ADDR_SECONDS) vlow_nxt = data_r[7];
          end else if (is_alarm) begin
            alarm_nxt[aidx] = data_r & alarm_mask;
          end else if (ptr_r == ADDR_CLKOUT) begin
            clkout_nxt = data_r & CTL_MASK;
          end else if (ptr_r == ADDR_TMRCTL) begin
            tmrctl_nxt = data_r & CTL_MASK;
            if (!data_r[TC_TE]) run_nxt = 1'b0;
          end else if (ptr_r == ADDR_TMRCNT) begin
            tmrcnt_nxt = data_r;
            if (tmrctl_r[TC_TE]) run_nxt = 1'b1;
          end
        end
      end
      OP_READ: begin
        ptr_nxt = ptr_r + 8'd1;
        if (ptr_r == ADDR_CTRL1)        res_nxt.read_data = ctrl1_r;
        else if (ptr_r == ADDR_CTRL2)   res_nxt.read_data = {3'd0, ctrl2_r};
        else if (ptr_r == ADDR_SECONDS) res_nxt.read_data = {vlow_r, 7'd0} |
                                                            bcd_encode(time_r[0]);
        else if (is_time)               res_nxt.read_data = bcd_encode(time_r[tidx]);
        else if (is_alarm)              res_nxt.read_data = alarm_r[aidx];
        else if (ptr_r == ADDR_CLKOUT)  res_nxt.read_data = clkout_r;
        else if (ptr_r == ADDR_TMRCTL)  res_nxt.read_data = tmrctl_r;
        else if (ptr_r == ADDR_TMRCNT)  res_nxt.read_data = tmrcnt_r;
      end
      OP_FINISH: begin
        expa_nxt = 1'b1;
        ev = irq_eval(ctrl2_r);
        irq_nxt = ev[1];
        res_nxt.irq_pulse = ev[0];
      end
      OP_EVENT: begin
        if (tick_r) begin
          // Count down on the selected source while running, expire at one or zero
          if (run_r && (src_r == tmrctl_r[1:0])) begin
            if (tmrcnt_r <= 8'd1) begin
              tmrcnt_nxt = 8'd0;
              run_nxt    = 1'b0;
              ctrl2_nxt[C2_TF] = 1'b1;
              ev = irq_eval(ctrl2_nxt);
              irq_nxt = ev[1];
              res_nxt.irq_pulse = ev[0];
            end else begin
              tmrcnt_nxt = tmrcnt_r - 8'd1;
            end
          end
        end else begin
          // Alarm match: raise the flag and re-evaluate
          ctrl2_nxt[C2_AF] = 1'b1;
          ev = irq_eval(ctrl2_nxt);
          irq_nxt = ev[1];
          res_nxt.irq_pulse = ev[0];
        end
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
    res_nxt.irq_level = irq_nxt;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      ptr_r    <= 8'd0;
      expa_r   <= 1'b1;
      ctrl1_r  <= CTRL1_RST;
      ctrl2_r  <= 5'd0;
      vlow_r   <= 1'b1;
      for (int i = 0; i < NUM_TIME; i++) time_r[i] <= 7'd0;
      for (int i = 0; i < NUM_ALARM; i++) alarm_r[i] <= ALARM_RST;
      clkout_r <= CTL_RST;
      tmrctl_r <= CTL_RST;
      tmrcnt_r <= 8'd0;
      run_r    <= 1'b0;
      irq_r    <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
      // Commit state only when the request moves to the result register
      if (adv && in_v_r) begin
        ptr_r    <= ptr_nxt;
        expa_r   <= expa_nxt;
        ctrl1_r  <= ctrl1_nxt;
        ctrl2_r  <= ctrl2_nxt;
        vlow_r   <= vlow_nxt;
        time_r   <= time_nxt;
        alarm_r  <= alarm_nxt;
        clkout_r <= clkout_nxt;
        tmrctl_r <= tmrctl_nxt;
        tmrcnt_r <= tmrcnt_nxt;
        run_r    <= run_nxt;
        irq_r    <= irq_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r   <= rtcrf_op_t'(in_ch.opcode);
      data_r <= in_ch.data_byte;
      src_r  <= in_ch.tick_source;
      tick_r <= in_ch.is_tick;
    end
    if (adv && in_v_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtcrf_checker.sv
// ----------------------------------------------------------------------------
// rtcrf_checker
// Port-level checks of the RTC register file: reset, occupancy and result
// stability under backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcrf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data,
  input wire logic       out_irq_level,
  input wire logic       out_irq_pulse
);

  logic [1:0] occ_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests held inside the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else if (in_acc && !out_acc) begin
      occ_r <= occ_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      occ_r <= occ_r - 2'd1;
    end
  end

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Never more than two requests in flight
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 2'd2)
    else $error("more than two requests held");

  // Each result belongs to an accepted request
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != 2'd0)
    else $error("result without a request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_irq_level) && $stable(out_irq_pulse))
    else $error("stalled result changed");

endmodule

bind i2c_rtc_register_file rtcrf_checker u_rtcrf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_irq_level (out_ch.irq_level),
  .out_irq_pulse (out_ch.irq_pulse)
);

`default_nettype wire

// File: dv/i2c_rtc_register_file_tb.sv
// ----------------------------------------------------------------------------
// i2c_rtc_register_file_tb
// Self-checking bench for the RTC register file. Requests go in over the
// valid/ready channel, every result is compared with a register-level
// prediction of the pointer, time fields, masks, countdown timer and
// interrupt logic. Directed checks come first, then random bus transfers
// and time events under three back-pressure mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rtc_register_file_tb;

  import rtcrf_pkg::*;

  // Time field slots, in address order from the seconds register
  localparam int FLD_SECONDS = 0;
  localparam int FLD_MINUTES = 1;
  localparam int FLD_HOURS   = 2;
  localparam int FLD_DAYS    = 3;
  localparam int FLD_WDAYS   = 4;
  localparam int FLD_MONTHS  = 5;

  // Timer tick sources
  localparam logic [1:0] SRC_4096HZ = 2'd0;
  localparam logic [1:0] SRC_64HZ   = 2'd1;

  localparam logic [7:0] ADDR_LAST = 8'hFF;

  localparam int RANDOM_ITEMS_PER_PHASE = 570;
  localparam int WATCHDOG_TIME          = 400000;

  logic clk = 1'b0;
  logic rst_n;

  rtcrf_in_if  in_ch ();
  rtcrf_out_if out_ch ();

  i2c_rtc_register_file uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Register file image kept by the bench
  logic [7:0] rf_ptr;
  logic       rf_addr_phase;
  logic [7:0] rf_ctrl1;
  logic [4:0] rf_ctrl2;
  logic       rf_vlow;
  logic [6:0] rf_time [7];
  logic [7:0] rf_alarm [4];
  logic [7:0] rf_clkout;
  logic [7:0] rf_tmr_ctl;
  logic [7:0] rf_tmr_cnt;
  logic       rf_tmr_on;
  logic       rf_irq;

  rtcrf_result_t pending_responses [$];

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int items_sent        = 0;
  int results_checked   = 0;
  int mismatches        = 0;
  int timer_expiries    = 0;
  int pulses_predicted  = 0;
  int op_count [4]      = '{0, 0, 0, 0};

  // Free-running clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #(WATCHDOG_TIME);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Register file prediction
  // --------------------------------------------------------------------------

  function automatic logic [7:0] field_mask(input int idx);
    case (idx)
      FLD_SECONDS, FLD_MINUTES: return 8'h7F;
      FLD_HOURS, FLD_DAYS:      return 8'h3F;
      FLD_WDAYS:                return 8'h07;
      FLD_MONTHS:               return 8'h1F;
      default:                  return 8'hFF;
    endcase
  endfunction

  function automatic int field_lo(input int idx);
    return (idx == FLD_DAYS || idx == FLD_MONTHS) ? 1 : 0;
  endfunction

  function automatic int field_hi(input int idx);
    case (idx)
      FLD_SECONDS, FLD_MINUTES: return 59;
      FLD_HOURS:                return 23;
      FLD_DAYS:                 return 31;
      FLD_WDAYS:                return 6;
      FLD_MONTHS:               return 12;
      default:                  return 99;
    endcase
  endfunction

  function automatic logic [7:0] bcd_digits(input int v);
    logic [7:0] r;
    r = 8'(((v / 10) % 10) * 16 + (v % 10));
    return r;
  endfunction

  task automatic reset_register_image();
    rf_ptr        = 8'h00;
    rf_addr_phase = 1'b1;
    rf_ctrl1      = CTRL1_RST;
    rf_ctrl2      = 5'd0;
    rf_vlow       = 1'b1;
    foreach (rf_time[i]) rf_time[i] = 7'd0;
    foreach (rf_alarm[i]) rf_alarm[i] = ALARM_RST;
    rf_clkout     = CTL_RST;
    rf_tmr_ctl    = CTL_RST;
    rf_tmr_cnt    = 8'h00;
    rf_tmr_on     = 1'b0;
    rf_irq        = 1'b0;
  endtask

  // Recompute the interrupt line from the flags and enables
  task automatic reevaluate_irq(output logic pulse);
    pulse  = 1'b0;
    rf_irq = 1'b0;
    if (rf_ctrl2[C2_TF] && rf_ctrl2[C2_TIE]) begin
      if (rf_ctrl2[C2_TI_TP]) pulse = 1'b1;
      else rf_irq = 1'b1;
    end
    if (rf_ctrl2[C2_AF] && rf_ctrl2[C2_AIE]) rf_irq = 1'b1;
  endtask

  function automatic logic [7:0] read_register(input logic [7:0] a);
    if (a == ADDR_CTRL1) return rf_ctrl1;
    if (a == ADDR_CTRL2) return {3'b000, rf_ctrl2};
    if (a == ADDR_SECONDS)
      return {rf_vlow, 7'd0} | bcd_digits(int'(rf_time[FLD_SECONDS]));
    if (a > ADDR_SECONDS && a <= ADDR_YEARS)
      return bcd_digits(int'(rf_time[3'(a - ADDR_SECONDS)]));
    if (a >= ADDR_ALARM0 && a <= ADDR_ALARM3) return rf_alarm[2'(a - ADDR_ALARM0)];
    if (a == ADDR_CLKOUT) return rf_clkout;
    if (a == ADDR_TMRCTL) return rf_tmr_ctl;
    if (a == ADDR_TMRCNT) return rf_tmr_cnt;
    return UNMAPPED;
  endfunction

  task automatic write_register(input logic [7:0] a, input logic [7:0] d);
    int idx;
    int t;
    if (a == ADDR_CTRL1) begin
      rf_ctrl1 = d & CTRL1_MASK;
    end else if (a == ADDR_CTRL2) begin
      rf_ctrl2 = d[4:0] & CTRL2_MASK;
    end else if (a >= ADDR_SECONDS && a <= ADDR_YEARS) begin
      // Decode BCD, drop the value when out of range
      idx = int'(a - ADDR_SECONDS);
      t = ((d & field_mask(idx)) >> 4) * 10 + (d & field_mask(idx) & 8'h0F);
      if (t >= field_lo(idx) && t <= field_hi(idx)) rf_time[idx] = t[6:0];
      if (idx == FLD_SECONDS) rf_vlow = d[7];
    end else if (a == ADDR_ALARM0) begin
      rf_alarm[0] = d;
    end else if (a > ADDR_ALARM0 && a < ADDR_ALARM3) begin
      rf_alarm[2'(a - ADDR_ALARM0)] = d & ALARM_MASK;
    end else if (a == ADDR_ALARM3) begin
      rf_alarm[3] = d & WDAY_MASK;
    end else if (a == ADDR_CLKOUT) begin
      rf_clkout = d & CTL_MASK;
    end else if (a == ADDR_TMRCTL) begin
      rf_tmr_ctl = d & CTL_MASK;
      if (!rf_tmr_ctl[TC_TE]) rf_tmr_on = 1'b0;
    end else if (a == ADDR_TMRCNT) begin
      rf_tmr_cnt = d;
      if (rf_tmr_ctl[TC_TE]) rf_tmr_on = 1'b1;
    end
  endtask

  // Apply one request to the image and return the response it produces
  task automatic compute_register_response(
    input  logic [1:0]    op,
    input  logic [7:0]    d,
    input  logic [1:0]    src,
    input  logic          tk,
    output rtcrf_result_t resp
  );
    logic pulse;
    resp.read_data = UNMAPPED;
    pulse = 1'b0;
    op_count[op]++;
    if (op == OP_WRITE) begin
      if (rf_addr_phase) begin
        rf_ptr        = d;
        rf_addr_phase = 1'b0;
      end else begin
        write_register(rf_ptr, d);
        rf_ptr = rf_ptr + 8'd1;
      end
    end else if (op == OP_READ) begin
      resp.read_data = read_register(rf_ptr);
      rf_ptr = rf_ptr + 8'd1;
    end else if (op == OP_FINISH) begin
      rf_addr_phase = 1'b1;
      reevaluate_irq(pulse);
    end else if (tk) begin
      // Count down only on the selected source while running
      if (rf_tmr_on && src == rf_tmr_ctl[1:0]) begin
        if (rf_tmr_cnt <= 8'd1) begin
          rf_tmr_cnt = 8'd0;
          rf_tmr_on  = 1'b0;
          rf_ctrl2[C2_TF] = 1'b1;
          timer_expiries++;
          reevaluate_irq(pulse);
        end else begin
          rf_tmr_cnt = rf_tmr_cnt - 8'd1;
        end
      end
    end else begin
      rf_ctrl2[C2_AF] = 1'b1;
      reevaluate_irq(pulse);
    end
    if (pulse) pulses_predicted++;
    resp.irq_level = rf_irq;
    resp.irq_pulse = pulse;
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Entered at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(
    input logic [1:0] op,
    input logic [7:0] d,
    input logic [1:0] src,
    input logic       tk
  );
    rtcrf_result_t resp;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.data_byte   <= d;
    in_ch.tick_source <= src;
    in_ch.is_tick     <= tk;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    compute_register_response(op, d, src, tk, resp);
    pending_responses.push_back(resp);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_write(input logic [7:0] d);
    send_req(OP_WRITE, d, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  task automatic send_read();
    send_req(OP_READ, 8'($urandom_range(255)), 2'($urandom_range(3)),
             1'($urandom_range(1)));
  endtask

  task automatic send_finish();
    send_req(OP_FINISH, 8'($urandom_range(255)), 2'($urandom_range(3)),
             1'($urandom_range(1)));
  endtask

  task automatic send_tick(input logic [1:0] src);
    send_req(OP_EVENT, 8'($urandom_range(255)), src, 1'b1);
  endtask

  task automatic send_alarm();
    send_req(OP_EVENT, 8'($urandom_range(255)), 2'($urandom_range(3)), 1'b0);
  endtask

  // Mostly ticks on the running source, some foreign ticks and alarms
  task automatic send_random_event();
    if ($urandom_range(99) < 15) send_alarm();
    else if ($urandom_range(99) < 70) send_tick(rf_tmr_ctl[1:0]);
    else send_tick(2'($urandom_range(3)));
  endtask

  // Hold off new requests until every response is back
  task automatic wait_for_responses();
    in_ch.valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 8'($urandom_range(15));
    if (r < 85) return 8'hF0 | 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  // Data biased toward legal BCD for time fields, short timer counts and the timer enable bit
  function automatic logic [7:0] pick_data(input logic [7:0] a);
    logic [7:0] d;
    int idx;
    d = 8'($urandom_range(255));
    if (a >= ADDR_SECONDS && a <= ADDR_YEARS && $urandom_range(99) < 75) begin
      idx = int'(a - ADDR_SECONDS);
      d = bcd_digits(int'($urandom_range(field_hi(idx), field_lo(idx)))) |
          (d & ~field_mask(idx));
    end else if (a == ADDR_TMRCNT && $urandom_range(99) < 80) begin
      d = 8'($urandom_range(5));
    end else if (a == ADDR_TMRCTL && $urandom_range(99) < 70) begin
      d[TC_TE] = 1'b1;
    end
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s at response %0d: expected %02h, got %02h",
               what, results_checked, want, got);
  endtask

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin : check_responses
    rtcrf_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_checked++;
      if (pending_responses.size() == 0) begin
        note_mismatch("unexpected response, read_data", UNMAPPED, out_ch.read_data);
      end else begin
        want = pending_responses.pop_front();
        if (out_ch.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, out_ch.read_data);
        if (out_ch.irq_level !== want.irq_level)
          note_mismatch("irq_level", {7'd0, want.irq_level}, {7'd0, out_ch.irq_level});
        if (out_ch.irq_pulse !== want.irq_pulse)
          note_mismatch("irq_pulse", {7'd0, want.irq_pulse}, {7'd0, out_ch.irq_pulse});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Unmapped reads, pointer wrap past the top and reset values
  task automatic test_unmapped_and_wrap();
    send_finish();
    send_write(ADDR_LAST - 8'd1);
    send_read();
    send_read();
    send_read();
    send_read();
  endtask

  // Out-of-range time writes are dropped; the century bit reads back as 0
  task automatic test_time_fields();
    send_finish();
    send_write(8'(ADDR_SECONDS + FLD_WDAYS));
    send_write(8'h07);
    send_write(8'h92);
    send_write(8'hFF);
    send_finish();
    send_write(8'(ADDR_SECONDS + FLD_WDAYS));
    send_read();
    send_read();
  endtask

  // Ignored ticks while stopped and from another source, then expiry
  task automatic test_timer_countdown();
    send_tick(SRC_64HZ);
    send_finish();
    send_write(ADDR_TMRCTL);
    send_write({1'b1, 5'd0, SRC_64HZ});
    send_write(8'h02);
    send_tick(SRC_4096HZ);
    send_tick(SRC_64HZ);
    send_tick(SRC_64HZ);
  endtask

  // Enables land at the next evaluation: alarm event, then finish
  task automatic test_irq_evaluation();
    send_finish();
    send_write(ADDR_CTRL2);
    send_write(8'h1F);
    send_alarm();
    send_finish();
  endtask

  // Random transfers and time events, mostly well formed
  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int pick;
    logic [7:0] d;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // Write transfer; now and then the leading finish is missing
        if ($urandom_range(9) != 0) send_finish();
        send_write(pick_address());
        repeat ($urandom_range(4, 1)) send_write(pick_data(rf_ptr));
      end else if (pick < 65) begin
        send_finish();
        send_write(pick_address());
        repeat ($urandom_range(5, 1)) send_read();
      end else if (pick < 80) begin
        // Arm the timer and feed it ticks
        send_finish();
        send_write(ADDR_TMRCTL);
        d = 8'($urandom_range(255));
        d[TC_TE] = ($urandom_range(9) != 0);
        send_write(d);
        send_write(8'($urandom_range(6)));
        repeat ($urandom_range(10, 1)) send_random_event();
      end else if (pick < 95) begin
        repeat ($urandom_range(6, 1)) send_random_event();
      end else begin
        repeat ($urandom_range(3, 1))
          send_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                   2'($urandom_range(3)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_FINISH;
    in_ch.data_byte   = 8'h00;
    in_ch.tick_source = SRC_4096HZ;
    in_ch.is_tick     = 1'b0;
    reset_register_image();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unmapped_and_wrap();
    test_time_fields();
    test_timer_countdown();
    test_irq_evaluation();
    wait_for_responses();

    sender_idle_pct   = 15;
    receiver_idle_pct = 74;
    test_random_traffic(RANDOM_ITEMS_PER_PHASE);
    wait_for_responses();

    sender_idle_pct   = 74;
    receiver_idle_pct = 15;
    test_random_traffic(RANDOM_ITEMS_PER_PHASE);
    wait_for_responses();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS_PER_PHASE);
    wait_for_responses();

    // Let any stray response show up
    repeat (8) @(negedge clk);

    $display("Sent %0d requests: %0d writes, %0d reads, %0d finishes, %0d time events",
             items_sent, op_count[OP_WRITE], op_count[OP_READ], op_count[OP_FINISH],
             op_count[OP_EVENT]);
    $display("Checked %0d responses with %0d timer expiries, %0d irq pulses, %0d mismatches",
             results_checked, timer_expiries, pulses_predicted, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/rtcrf_pkg.sv
rtl/core/rtcrf_chan_if.sv
rtl/core/i2c_rtc_register_file.sv
rtl/core/rtcrf_checker.sv
dv/i2c_rtc_register_file_tb.sv
